>>> design/tlvd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlvd_pkg: shared types and constants for the TLV length deframer
// Payload structs for the byte and result channels, status codes and
// configuration register indexes.
// ----------------------------------------------------------------------------
package tlvd_pkg;

   // Header: type, flags, length high, length low
   localparam logic [15:0] HEADER_BYTES     = 16'd4;
   localparam logic [15:0] HEADER_LAST      = HEADER_BYTES - 16'd1;
   localparam logic [15:0] LEN_HIGH_OFFSET  = 16'd2;
   localparam logic [15:0] NOTIFY_MAX_BYTES = 16'd256;

   localparam logic [15:0] MAX_SIZE_RESET   = 16'hFFFF;
   localparam logic [15:0] DELIV_RESET      = 16'hFFFF;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROTOCOL_MODE    = 2'd0,
      CSR_MAX_MESSAGE_SIZE = 2'd1,
      CSR_DELIVERY_LIMIT   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      STATUS_PARTIAL  = 2'd0,
      STATUS_COMPLETE = 2'd1,
      STATUS_ERROR    = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_record;
      logic       notification;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic [15:0] byte_offset;
      logic [1:0]  status;
      logic [15:0] message_length;
      logic        notification_message;
   } rsp_payload_type;

endpackage

>>> design/tlv_length_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_length_deframer_top: length-prefixed message deframer
// Passes each received byte through with its offset in the current message
// and a status: partial, last byte of a complete message, or stream error.
//
//   channel   direction   handshake              payload
//   req_      in          req_valid / req_stall  tlvd_pkg::req_payload_type
//   rsp_      out         rsp_valid / rsp_stall  tlvd_pkg::rsp_payload_type
//   csr_      in          csr_we                 csr_index, csr_wdata
//
// One byte per cycle while req_stall is low; each byte is on rsp_ the cycle
// after its transfer. Framing state and the result are updated in one pass
// from the byte and the state registers, and the result lands in one output
// register. req_stall is high only while the output register holds a result
// that rsp_stall keeps from moving. Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module tlv_length_deframer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  tlvd_pkg::req_payload_type     req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output tlvd_pkg::rsp_payload_type     rsp_payload,
   input  logic                          csr_we,
   input  logic [tlvd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [tlvd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tlvd_pkg::*;

   typedef enum logic [1:0] {
      PH_HEADER = 2'd0,
      PH_BODY   = 2'd1,
      PH_ERROR  = 2'd2
   } phase_type;

   // Configuration
   logic        mode_ff;
   logic [15:0] max_size_ff;
   logic [15:0] deliv_limit_ff;

   // Framing state
   phase_type   phase_ff, phase_in;
   logic [15:0] bytes_read_ff, bytes_read_in;
   logic [15:0] message_size_ff, message_size_in;
   logic [7:0]  length_high_ff, length_high_in;
   logic        in_notif_ff, in_notif_in;

   // Output register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic accept;
   logic rec, eor, ntf;
   logic done;
   status_type status;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   assign rec = mode_ff;
   assign eor = rec & req_payload.end_of_record;
   assign ntf = rec & req_payload.notification;

   always_comb begin
      phase_in        = phase_ff;
      bytes_read_in   = bytes_read_ff;
      message_size_in = message_size_ff;
      length_high_in  = length_high_ff;
      in_notif_in     = in_notif_ff;
      status          = STATUS_PARTIAL;
      done            = 1'b1;

      rsp_payload_in.out_byte             = req_payload.data_byte;
      rsp_payload_in.byte_offset          = 16'd0;
      rsp_payload_in.status               = STATUS_ERROR;
      rsp_payload_in.message_length       = 16'd0;
      rsp_payload_in.notification_message = 1'b0;

      if (phase_ff == PH_ERROR && !rec) begin
         // stream mode: the error is sticky, hold all state
      end else begin
         if (phase_ff == PH_ERROR) begin
            phase_in        = PH_HEADER;
            bytes_read_in   = 16'd0;
            message_size_in = 16'd0;
            in_notif_in     = 1'b0;
         end

         rsp_payload_in.byte_offset = bytes_read_in;
         bytes_read_in = bytes_read_in + 16'd1;

         if (phase_in == PH_HEADER) begin
            if (ntf) begin
               message_size_in = NOTIFY_MAX_BYTES;
               in_notif_in     = 1'b1;
               phase_in        = PH_BODY;
            end else if (rsp_payload_in.byte_offset == LEN_HIGH_OFFSET) begin
               length_high_in = req_payload.data_byte;
            end else if (rsp_payload_in.byte_offset >= HEADER_LAST) begin
               message_size_in = {length_high_ff, req_payload.data_byte};
               if (message_size_in < HEADER_BYTES || message_size_in > max_size_ff) begin
                  status = STATUS_ERROR;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            // record end inside the header
            if (phase_in == PH_HEADER && status == STATUS_PARTIAL && eor) begin
               status = STATUS_ERROR;
            end
         end

         if (status == STATUS_PARTIAL && phase_in == PH_BODY) begin
            if (bytes_read_in < message_size_in) begin
               if (eor) begin
                  if (!ntf) begin
                     status = STATUS_ERROR;
                  end else begin
                     // record end closes the notification early
                     message_size_in = bytes_read_in;
                  end
               end else begin
                  done = 1'b0;
               end
            end
            if (status == STATUS_PARTIAL && done) begin
               if (message_size_in > deliv_limit_ff) begin
                  status = STATUS_ERROR;
               end else if (rec && !eor) begin
                  status = STATUS_ERROR;
               end else begin
                  status = STATUS_COMPLETE;
                  rsp_payload_in.message_length = message_size_in;
               end
            end
         end

         rsp_payload_in.status               = status;
         rsp_payload_in.notification_message = in_notif_in;

         if (status == STATUS_ERROR) begin
            phase_in    = PH_ERROR;
            in_notif_in = 1'b0;
         end else if (status == STATUS_COMPLETE) begin
            phase_in        = PH_HEADER;
            bytes_read_in   = 16'd0;
            message_size_in = 16'd0;
            in_notif_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= 1'b0;
         max_size_ff     <= MAX_SIZE_RESET;
         deliv_limit_ff  <= DELIV_RESET;
         phase_ff        <= PH_HEADER;
         bytes_read_ff   <= 16'd0;
         message_size_ff <= 16'd0;
         length_high_ff  <= 8'd0;
         in_notif_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_PROTOCOL_MODE:    mode_ff        <= csr_wdata[0];
               CSR_MAX_MESSAGE_SIZE: max_size_ff    <= csr_wdata;
               CSR_DELIVERY_LIMIT:   deliv_limit_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
         if (accept) begin
            phase_ff        <= phase_in;
            bytes_read_ff   <= bytes_read_in;
            message_size_ff <= message_size_in;
            length_high_ff  <= length_high_in;
            in_notif_ff     <= in_notif_in;
            // payload register: load on transfer, hold while stalled
            rsp_payload_ff  <= rsp_payload_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   // notification flag only lives inside a message body
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_BODY |-> !in_notif_ff)
      else $error("notification flag set outside a message body");

   // an open body always has bytes left to read
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> bytes_read_ff < message_size_ff)
      else $error("body open with no bytes left");

   // stream mode error is sticky
   assert property (@(posedge clock) disable iff (reset)
      accept && phase_ff == PH_ERROR && !mode_ff
      |=> rsp_payload.status == STATUS_ERROR && phase_ff == PH_ERROR)
      else $error("stream mode error did not stick");
`endif

endmodule
